### design/fcmd_pkg.sv
// Shared types and constants for the framed command table port.
package fcmd_pkg;

  // Frame bytes and command codes.
  localparam logic [7:0] SYNC_FIRST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND    = 8'h55;
  localparam logic [7:0] CMD_READ       = 8'h10;
  localparam logic [7:0] CMD_WRITE      = 8'h20;
  localparam logic [7:0] CODE_BAD_SUM   = 8'h80;
  localparam logic [7:0] CODE_BAD_CMD   = 8'h81;
  localparam logic [7:0] CODE_BAD_INDEX = 8'h82;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // What the back end has to do for one accepted item.
  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_ERROR,
    JOB_READ,
    JOB_WRITE
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  code;
    logic [7:0]  idx;
    logic [1:0]  status;
  } job_t;

endpackage

### design/fcmd_front.sv
// Frame receiver: tracks sync, length, checksum and timeout, and classifies each item.
module fcmd_front #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ENTRY_BYTES   = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       opcode,
  input  logic [7:0]                 rx_byte,
  input  logic                       cfg_we,
  input  logic [15:0]                cfg_wdata,
  output fcmd_pkg::job_t             job,
  output logic [8*ENTRY_BYTES-1:0]   job_payload
);

  localparam logic [7:0] MIN_LENGTH = 8'd3;

  logic [15:0]              timeout_limit;
  logic [8:0]               byte_count;
  logic [7:0]               frame_length;
  logic [7:0]               running_sum;
  logic [7:0]               command_code;
  logic [7:0]               entry_index;
  logic [8*ENTRY_BYTES-1:0] payload;
  logic [15:0]              elapsed_ms;

  logic [8:0]  end_pos;
  logic [15:0] elapsed_inc;

  assign end_pos     = {1'b0, frame_length} + 9'd2;
  assign elapsed_inc = (elapsed_ms != 16'hFFFF) ? elapsed_ms + 16'd1 : elapsed_ms;
  assign job_payload = payload;

  // Classification of the item currently offered.
  always_comb begin
    job.kind   = fcmd_pkg::JOB_STATUS;
    job.code   = 8'd0;
    job.idx    = entry_index;
    job.status = fcmd_pkg::ST_OK;
    if (!opcode) begin
      if (byte_count == 9'd0) begin
        if (rx_byte != fcmd_pkg::SYNC_FIRST) job.status = fcmd_pkg::ST_ERR;
      end else if (byte_count == 9'd1) begin
        if (rx_byte != fcmd_pkg::SYNC_SECOND) job.status = fcmd_pkg::ST_ERR;
      end else if (byte_count == 9'd2) begin
        if (rx_byte < MIN_LENGTH) job.status = fcmd_pkg::ST_ERR;
      end else if (byte_count == end_pos) begin
        if (running_sum != rx_byte) begin
          job.kind   = fcmd_pkg::JOB_ERROR;
          job.code   = fcmd_pkg::CODE_BAD_SUM;
          job.status = fcmd_pkg::ST_ERR;
        end else if (entry_index >= 8'(TABLE_ENTRIES)) begin
          job.kind   = fcmd_pkg::JOB_ERROR;
          job.code   = fcmd_pkg::CODE_BAD_INDEX;
          job.status = fcmd_pkg::ST_ERR;
        end else if (command_code == fcmd_pkg::CMD_READ) begin
          job.kind = fcmd_pkg::JOB_READ;
          job.code = fcmd_pkg::CMD_READ;
        end else if (command_code == fcmd_pkg::CMD_WRITE) begin
          job.kind   = fcmd_pkg::JOB_WRITE;
          job.code   = fcmd_pkg::CMD_WRITE;
          job.status = (entry_index == 8'(TABLE_ENTRIES - 1)) ? fcmd_pkg::ST_LAST
                                                              : fcmd_pkg::ST_OK;
        end else begin
          job.kind   = fcmd_pkg::JOB_ERROR;
          job.code   = fcmd_pkg::CODE_BAD_CMD;
          job.status = fcmd_pkg::ST_ERR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= fcmd_pkg::TIMEOUT_RESET;
      byte_count    <= 9'd0;
      frame_length  <= 8'd0;
      running_sum   <= 8'd0;
      command_code  <= 8'd0;
      entry_index   <= 8'd0;
      payload       <= '0;
      elapsed_ms    <= 16'd0;
    end else begin
      if (cfg_we) timeout_limit <= cfg_wdata;
      if (accept && !opcode) begin
        if (byte_count == 9'd0) begin
          if (rx_byte == fcmd_pkg::SYNC_FIRST) begin
            elapsed_ms  <= 16'd0;
            running_sum <= rx_byte;
            payload     <= '0;
            byte_count  <= 9'd1;
          end
        end else if (byte_count == 9'd1) begin
          if (rx_byte != fcmd_pkg::SYNC_SECOND) begin
            byte_count <= 9'd0;
          end else begin
            running_sum <= running_sum + rx_byte;
            byte_count  <= 9'd2;
          end
        end else if (byte_count == 9'd2) begin
          if (rx_byte < MIN_LENGTH) begin
            byte_count <= 9'd0;
          end else begin
            frame_length <= rx_byte;
            running_sum  <= running_sum + rx_byte;
            byte_count   <= 9'd3;
          end
        end else if (byte_count == end_pos) begin
          byte_count <= 9'd0;
        end else begin
          if (byte_count == 9'd3) command_code <= rx_byte;
          if (byte_count == 9'd4) entry_index <= rx_byte;
          for (int j = 0; j < ENTRY_BYTES; j++) begin
            if (byte_count == 9'(j + 5)) payload[8*j +: 8] <= rx_byte;
          end
          running_sum <= running_sum + rx_byte;
          byte_count  <= byte_count + 9'd1;
        end
      end else if (accept && opcode && byte_count != 9'd0) begin
        if (elapsed_inc > timeout_limit) begin
          byte_count <= 9'd0;
          elapsed_ms <= 16'd0;
        end else begin
          elapsed_ms <= elapsed_inc;
        end
      end
    end
  end

endmodule

### design/fcmd_fifo.sv
// Short register queue that carries jobs from the receiver to the responder.
module fcmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + NW'(1);
      else if (do_pop && !do_push) count <= count - NW'(1);
    end
  end

endmodule

### design/fcmd_back.sv
// Responder: owns the entry table and sends each job's result run.
module fcmd_back #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ENTRY_BYTES   = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     job_empty,
  input  fcmd_pkg::job_t           job_in,
  input  logic [8*ENTRY_BYTES-1:0] payload_in,
  output logic                     job_pop,
  input  logic                     pop,
  output logic                     empty,
  output logic [7:0]               tx_byte,
  output logic                     has_byte,
  output logic                     last,
  output logic [1:0]               status
);

  localparam int WORDS = TABLE_ENTRIES * ENTRY_BYTES;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW    = (ENTRY_BYTES > 1) ? $clog2(ENTRY_BYTES) : 1;
  localparam int CW    = $clog2(ENTRY_BYTES + 1);
  localparam int PW    = $clog2(ENTRY_BYTES + 6);

  localparam logic [PW-1:0] POS_SYNC1 = PW'(0);
  localparam logic [PW-1:0] POS_SYNC2 = PW'(1);
  localparam logic [PW-1:0] POS_LEN   = PW'(2);
  localparam logic [PW-1:0] POS_CODE  = PW'(3);
  localparam logic [PW-1:0] POS_INDEX = PW'(4);
  localparam logic [PW-1:0] POS_DATA  = PW'(5);

  typedef enum logic [1:0] {
    B_IDLE,
    B_COPY,
    B_SEND
  } back_state_t;

  back_state_t              state;
  fcmd_pkg::job_t           job;
  logic [8*ENTRY_BYTES-1:0] payload;
  logic [CW-1:0]            cnt;
  logic [PW-1:0]            pos;
  logic [7:0]               sum;
  logic                     out_valid;
  logic                     row_valid [TABLE_ENTRIES];

  logic [7:0]               mem [WORDS];
  logic [7:0]               mem_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_addr;
  logic [RW-1:0]            row;
  logic [EW-1:0]            cnt_sel;

  logic [7:0]               row_buf [ENTRY_BYTES];
  logic                     rd_pend;
  logic [EW-1:0]            rd_idx;

  logic [PW-1:0]            data_n;
  logic [PW-1:0]            data_off;
  logic [7:0]               emit_byte;
  logic                     emit_has;
  logic                     emit_last;
  logic [1:0]               emit_status;
  logic                     slot_free;

  assign row       = job.idx[RW-1:0];
  assign cnt_sel   = cnt[EW-1:0];
  assign mem_addr  = AW'(row) * AW'(ENTRY_BYTES) + AW'(cnt_sel);
  assign mem_we    = (state == B_COPY) && (job.kind == fcmd_pkg::JOB_WRITE);
  assign job_pop   = (state == B_IDLE) && !job_empty;
  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign data_off  = pos - POS_DATA;

  always_comb begin
    case (job.kind)
      fcmd_pkg::JOB_READ:  data_n = PW'(ENTRY_BYTES + 1);
      fcmd_pkg::JOB_WRITE: data_n = PW'(1);
      default:             data_n = PW'(0);
    endcase
  end

  // Byte at the current position of the answer frame.
  always_comb begin
    emit_byte   = 8'd0;
    emit_has    = 1'b1;
    emit_last   = 1'b0;
    emit_status = fcmd_pkg::ST_OK;
    if (job.kind == fcmd_pkg::JOB_STATUS) begin
      emit_has    = 1'b0;
      emit_last   = 1'b1;
      emit_status = job.status;
    end else if (pos == POS_SYNC1) begin
      emit_byte = fcmd_pkg::SYNC_FIRST;
    end else if (pos == POS_SYNC2) begin
      emit_byte = fcmd_pkg::SYNC_SECOND;
    end else if (pos == POS_LEN) begin
      emit_byte = 8'(data_n) + 8'd2;
    end else if (pos == POS_CODE) begin
      emit_byte = job.code;
    end else if (pos == POS_INDEX + data_n) begin
      emit_byte   = sum;
      emit_last   = 1'b1;
      emit_status = job.status;
    end else if (pos == POS_INDEX) begin
      emit_byte = job.idx;
    end else begin
      emit_byte = row_buf[data_off[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= payload[8*cnt_sel +: 8];
    mem_q <= mem[mem_addr];
  end

  // Rows never written read as zero.
  always_ff @(posedge clk) begin
    if (rd_pend) row_buf[rd_idx] <= row_valid[row] ? mem_q : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      for (int r = 0; r < TABLE_ENTRIES; r++) row_valid[r] <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!job_empty) begin
            job     <= job_in;
            payload <= payload_in;
            cnt     <= '0;
            pos     <= '0;
            sum     <= 8'd0;
            if (job_in.kind == fcmd_pkg::JOB_READ || job_in.kind == fcmd_pkg::JOB_WRITE)
              state <= B_COPY;
            else
              state <= B_SEND;
          end
        end
        B_COPY: begin
          if (job.kind == fcmd_pkg::JOB_WRITE) begin
            cnt <= cnt + CW'(1);
            if (cnt == CW'(ENTRY_BYTES - 1)) begin
              row_valid[row] <= 1'b1;
              state          <= B_SEND;
            end
          end else begin
            rd_pend <= (cnt < CW'(ENTRY_BYTES));
            rd_idx  <= cnt_sel;
            if (cnt == CW'(ENTRY_BYTES)) state <= B_SEND;
            else                         cnt   <= cnt + CW'(1);
          end
        end
        B_SEND: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            tx_byte   <= emit_byte;
            has_byte  <= emit_has;
            last      <= emit_last;
            status    <= emit_status;
            sum       <= sum + emit_byte;
            pos       <= pos + PW'(1);
            if (emit_last) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_copy_only_table_jobs: assert property (@(posedge clk) disable iff (rst)
    state == B_COPY |-> (job.kind == fcmd_pkg::JOB_READ || job.kind == fcmd_pkg::JOB_WRITE))
    else $error("table sweep running for a job that does not touch the table");

  a_status_only_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last)
    else $error("status-only result not marked last");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    state == B_SEND && slot_free && emit_last |=> state == B_IDLE && out_valid && last)
    else $error("responder did not finish after the last result");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> state == B_IDLE)
    else $error("job taken while a run is in progress");

endmodule

### design/framed_command_table_port.sv
// Top level of the framed command table port.
//
// This block receives serial bytes and one-millisecond ticks as input items and
// parses frames of the form AA 55 LEN CMD IDX payload SUM, where LEN counts the
// bytes from CMD through SUM and SUM is the 8-bit sum of all bytes before it.
// Command 0x10 reads a table entry and command 0x20 writes one; the table holds
// TABLE_ENTRIES entries of ENTRY_BYTES bytes and is all zero after reset. Every
// item produces a run of results that ends with one marked last: a plain byte
// or tick gives a single status-only result, and a completed frame gives the
// bytes of an answer frame (AA 55 len cmd idx data sum), or a data-less error frame
// with code 0x80 (bad checksum), 0x81 (bad command) or 0x82 (bad index). A bad
// sync byte or a too-short length byte restarts the receiver and reports status
// 1; a partial frame older than timeout_limit ticks is dropped silently. The
// receiver classifies each item in the cycle it is accepted and hands a job to
// a short queue, so it keeps accepting items while the responder is busy; full
// rises only when that queue is full. The responder takes one job at a time:
// it takes a status-only job from the head of the queue and registers its
// result at the output, an error job goes straight to its answer frame, a write
// takes the job and sweeps the payload into the table memory (one byte per cycle
// through its single port) and then sends its answer, and a read fetches the
// entry into a row buffer and then sends its answer frame. The responder sends
// at most one result transfer per cycle through a single output register; a
// result that waits on pop holds the responder, and once the queue behind it
// fills the receiver raises full as well. The user must write the timeout
// register through cfg_we and cfg_wdata only while the block is idle; the block
// does not enforce this. The timeout register resets to 1000.
module framed_command_table_port #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ENTRY_BYTES   = 8,
  parameter int QUEUE_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte,
  output logic        has_byte,
  output logic        last,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int JW = $bits(fcmd_pkg::job_t);
  localparam int QW = JW + 8 * ENTRY_BYTES;

  logic                     accept;
  fcmd_pkg::job_t           front_job;
  logic [8*ENTRY_BYTES-1:0] front_payload;
  logic [QW-1:0]            q_rdata;
  logic                     q_empty;
  logic                     q_pop;
  fcmd_pkg::job_t           back_job;

  // An input transfer happens whenever push is high and the job queue has room.
  assign accept   = push && !full;
  assign back_job = fcmd_pkg::job_t'(q_rdata[QW-1 -: JW]);

  fcmd_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ENTRY_BYTES   (ENTRY_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .rx_byte     (rx_byte),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .job         (front_job),
    .job_payload (front_payload)
  );

  fcmd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata ({front_job, front_payload}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  fcmd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ENTRY_BYTES   (ENTRY_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_empty  (q_empty),
    .job_in     (back_job),
    .payload_in (q_rdata[8*ENTRY_BYTES-1:0]),
    .job_pop    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .tx_byte    (tx_byte),
    .has_byte   (has_byte),
    .last       (last),
    .status     (status)
  );

endmodule
